// ===== hw/rtl/fcpr_pkg.sv =====
// shared types, codes and defaults for the framed cipher packet receiver
package fcpr_pkg;

    // default frame geometry
    localparam int DEF_IV_BYTES    = 16;
    localparam int DEF_HASH_BYTES  = 32;
    localparam int DEF_BLOCK_BYTES = 16;

    // configuration reset values
    localparam logic [15:0] MAX_LEN_RESET = 16'd200;

    // input opcodes
    localparam logic OP_DATA    = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_SYNC_FIRST  = 3'd0,
        CFG_SYNC_SECOND = 3'd1,
        CFG_ALGORITHM   = 3'd2,
        CFG_MODE        = 3'd3,
        CFG_MAX_LENGTH  = 3'd4
    } fcpr_cfg_index_t;

    // parser phases
    typedef enum logic [3:0] {
        PH_SYNC1  = 4'd0,
        PH_SYNC2  = 4'd1,
        PH_ALGO   = 4'd2,
        PH_MODE   = 4'd3,
        PH_LEN_HI = 4'd4,
        PH_LEN_LO = 4'd5,
        PH_IV     = 4'd6,
        PH_CIPHER = 4'd7,
        PH_HASH   = 4'd8,
        PH_READY  = 4'd9,
        PH_ERROR  = 4'd10
    } fcpr_phase_t;

    // payload section tags
    typedef enum logic [1:0] {
        SEC_NONE   = 2'd0,
        SEC_IV     = 2'd1,
        SEC_CIPHER = 2'd2,
        SEC_HASH   = 2'd3
    } fcpr_section_t;

    // one received item
    typedef struct packed {
        logic       opcode;
        logic [7:0] rx_byte;
    } fcpr_item_t;

    // frame settings from the configuration registers
    typedef struct packed {
        logic [7:0]  sync_first;
        logic [7:0]  sync_second;
        logic [7:0]  algorithm_code;
        logic [7:0]  mode_code;
        logic [15:0] max_cipher_length;
    } fcpr_cfg_t;

    // one result item
    typedef struct packed {
        fcpr_section_t section;
        logic [7:0]    payload_byte;
        logic [15:0]   payload_index;
        logic          section_last;
        logic          packet_ready;
        logic          framing_error;
        logic [15:0]   cipher_length;
    } fcpr_result_t;

endpackage

// ===== hw/rtl/fcpr_frame_fsm.sv =====
// frame parser: phase, length and byte counter state with the per-byte step logic
module fcpr_frame_fsm
    import fcpr_pkg::*;
#(
    parameter int IV_BYTES    = DEF_IV_BYTES,
    parameter int HASH_BYTES  = DEF_HASH_BYTES,
    parameter int BLOCK_BYTES = DEF_BLOCK_BYTES
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         step_en,
    input  fcpr_item_t   item,
    input  fcpr_cfg_t    cfg,
    output fcpr_result_t result
);

    localparam int REM_W = $clog2(BLOCK_BYTES + 1);

    fcpr_phase_t        phase_reg,  phase_next;
    logic [15:0]        length_reg, length_next;
    logic [15:0]        count_reg,  count_next;
    logic [REM_W-1:0]   hi_rem_reg, hi_rem_next;

    // residue tables for the length check: high byte * 256 and low byte, mod block size
    logic [REM_W-1:0] hi_tab [256];
    logic [REM_W-1:0] lo_tab [256];

    for (genvar k = 0; k < 256; k++) begin : g_rem_tab
        localparam int HI_R = (k * 256) % BLOCK_BYTES;
        localparam int LO_R = k % BLOCK_BYTES;
        assign hi_tab[k] = REM_W'(HI_R);
        assign lo_tab[k] = REM_W'(LO_R);
    end

    // parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_SYNC1;
            length_reg <= '0;
            count_reg  <= '0;
            hi_rem_reg <= '0;
        end else if (step_en) begin
            phase_reg  <= phase_next;
            length_reg <= length_next;
            count_reg  <= count_next;
            hi_rem_reg <= hi_rem_next;
        end
    end

    // next state and result for the current item
    always_comb begin
        logic [7:0]   data;
        logic         err;
        logic [16:0]  inc;
        logic [16:0]  limit;
        logic         last;
        logic         take;
        logic [REM_W:0] rem_sum;
        logic         rem_ok;
        logic [15:0]  len_full;

        data     = item.rx_byte;
        err      = 1'b0;
        inc      = {1'b0, count_reg} + 17'd1;
        limit    = '0;
        take     = 1'b0;
        rem_sum  = {1'b0, hi_rem_reg} + {1'b0, lo_tab[data]};
        rem_ok   = (rem_sum == '0) || (rem_sum == (REM_W+1)'(BLOCK_BYTES));
        len_full = {length_reg[15:8], data};

        phase_next  = phase_reg;
        length_next = length_reg;
        count_next  = count_reg;
        hi_rem_next = hi_rem_reg;
        result      = '0;

        if (item.opcode == OP_RESTART) begin
            phase_next  = PH_SYNC1;
            length_next = '0;
            count_next  = '0;
        end else begin
            unique case (phase_reg)
                PH_SYNC1: begin
                    if (data == cfg.sync_first) phase_next = PH_SYNC2;
                end
                PH_SYNC2: begin
                    phase_next = (data == cfg.sync_second) ? PH_ALGO : PH_SYNC1;
                end
                PH_ALGO: begin
                    if (data == cfg.algorithm_code) begin
                        phase_next = PH_MODE;
                    end else begin
                        phase_next = PH_ERROR;
                        err        = 1'b1;
                    end
                end
                PH_MODE: begin
                    if (data == cfg.mode_code) begin
                        phase_next = PH_LEN_HI;
                    end else begin
                        phase_next = PH_ERROR;
                        err        = 1'b1;
                    end
                end
                PH_LEN_HI: begin
                    length_next = {data, 8'h00};
                    hi_rem_next = hi_tab[data];
                    phase_next  = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    length_next = len_full;
                    if ((len_full == '0) || (len_full > cfg.max_cipher_length) || !rem_ok)
                    begin
                        phase_next = PH_ERROR;
                        err        = 1'b1;
                    end else begin
                        phase_next = PH_IV;
                        count_next = '0;
                    end
                end
                PH_IV: begin
                    take           = 1'b1;
                    limit          = 17'(IV_BYTES);
                    result.section = SEC_IV;
                end
                PH_CIPHER: begin
                    take           = 1'b1;
                    limit          = {1'b0, length_reg};
                    result.section = SEC_CIPHER;
                end
                PH_HASH: begin
                    take           = 1'b1;
                    limit          = 17'(HASH_BYTES);
                    result.section = SEC_HASH;
                end
                PH_READY: begin
                    phase_next = PH_READY;
                end
                default: begin
                    // error state and unused codes: discard the byte and clear
                    phase_next  = PH_SYNC1;
                    length_next = '0;
                    count_next  = '0;
                end
            endcase
        end

        // payload byte emission and section advance
        last = take && (inc >= limit);
        if (take) begin
            result.payload_byte  = data;
            result.payload_index = count_reg;
            result.section_last  = last;
            count_next           = last ? '0 : inc[15:0];
            if (last) begin
                unique case (phase_reg)
                    PH_IV:     phase_next = PH_CIPHER;
                    PH_CIPHER: phase_next = PH_HASH;
                    default:   phase_next = PH_READY;
                endcase
            end
        end

        result.packet_ready  = (phase_next == PH_READY);
        result.framing_error = err;
        result.cipher_length = length_next;
    end

endmodule

// ===== hw/rtl/framed_cipher_packet_receiver.sv =====
// top level of the framed cipher packet receiver: channels, config registers, pipeline
//
//  channel  | handshake                | payload
//  ---------+--------------------------+-----------------------------------------------
//  s_       | s_valid / s_ready        | s_opcode, s_rx_byte
//  m_       | m_valid / m_ready        | m_section, m_payload_byte, m_payload_index,
//           |                          | m_section_last, m_packet_ready,
//           |                          | m_framing_error, m_cipher_length
//  cfg_     | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
// one item per cycle unless m_ready stalls: a transfer lands in the input register, and the
// parser step runs between that register and the result register, which presents
// the result on the m_ channel.
// the input register refills in the same cycle it drains; a stalled m_ready
// holds both registers and then s_ready.
// aresetn is synchronous; it clears the parser and sets the config registers to their reset values.
module framed_cipher_packet_receiver
    import fcpr_pkg::*;
#(
    parameter int IV_BYTES    = DEF_IV_BYTES,
    parameter int HASH_BYTES  = DEF_HASH_BYTES,
    parameter int BLOCK_BYTES = DEF_BLOCK_BYTES
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_opcode,
    input  logic [7:0]  s_rx_byte,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_section,
    output logic [7:0]  m_payload_byte,
    output logic [15:0] m_payload_index,
    output logic        m_section_last,
    output logic        m_packet_ready,
    output logic        m_framing_error,
    output logic [15:0] m_cipher_length,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    fcpr_cfg_t    cfg_reg;
    logic         in_valid_reg;
    fcpr_item_t   in_item_reg;
    logic         out_valid_reg;
    fcpr_result_t out_result_reg;
    fcpr_result_t step_result;
    logic         advance;

    // configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sync_first        <= '0;
            cfg_reg.sync_second       <= '0;
            cfg_reg.algorithm_code    <= '0;
            cfg_reg.mode_code         <= '0;
            cfg_reg.max_cipher_length <= MAX_LEN_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_SYNC_FIRST:  cfg_reg.sync_first        <= cfg_data[7:0];
                CFG_SYNC_SECOND: cfg_reg.sync_second       <= cfg_data[7:0];
                CFG_ALGORITHM:   cfg_reg.algorithm_code    <= cfg_data[7:0];
                CFG_MODE:        cfg_reg.mode_code         <= cfg_data[7:0];
                CFG_MAX_LENGTH:  cfg_reg.max_cipher_length <= cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline flow control
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg.opcode  <= s_opcode;
            in_item_reg.rx_byte <= s_rx_byte;
        end
    end

    // parser step
    fcpr_frame_fsm #(
        .IV_BYTES    (IV_BYTES),
        .HASH_BYTES  (HASH_BYTES),
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_frame_fsm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .item    (in_item_reg),
        .cfg     (cfg_reg),
        .result  (step_result)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_result_reg <= step_result;
        end
    end

    // result channel
    assign m_valid         = out_valid_reg;
    assign m_section       = out_result_reg.section;
    assign m_payload_byte  = out_result_reg.payload_byte;
    assign m_payload_index = out_result_reg.payload_index;
    assign m_section_last  = out_result_reg.section_last;
    assign m_packet_ready  = out_result_reg.packet_ready;
    assign m_framing_error = out_result_reg.framing_error;
    assign m_cipher_length = out_result_reg.cipher_length;

endmodule

// ===== tb/tb_framed_cipher_packet_receiver.sv =====
// testbench for the framed cipher packet receiver: byte stream driver, result checker
`timescale 1ns / 1ps

module tb_framed_cipher_packet_receiver;
    import fcpr_pkg::*;

    localparam int IV_LEN    = DEF_IV_BYTES;
    localparam int HASH_LEN  = DEF_HASH_BYTES;
    localparam int BLOCK_LEN = DEF_BLOCK_BYTES;
    localparam int SETTLE_CYCLES = 8;
    localparam int PRINT_LIMIT   = 200;

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;

    logic        s_valid   = 1'b0;
    logic        s_ready;
    logic        s_opcode  = OP_DATA;
    logic [7:0]  s_rx_byte = 8'h00;

    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_section;
    logic [7:0]  m_payload_byte;
    logic [15:0] m_payload_index;
    logic        m_section_last;
    logic        m_packet_ready;
    logic        m_framing_error;
    logic [15:0] m_cipher_length;

    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = 3'd0;
    logic [15:0] cfg_data  = 16'h0000;

    // byte stream waiting to be offered, and results predicted for accepted bytes
    fcpr_item_t   rx_stream[$];
    fcpr_result_t predicted[$];
    int unsigned  stream_count = 0;
    int unsigned  mismatch_count = 0;

    // traffic shaping, set between clock edges by the sequencer
    int unsigned  send_idle_pct  = 0;
    int unsigned  recv_stall_pct = 0;
    int unsigned  hold_request   = 0;
    int unsigned  hold_left      = 0;

    // parser model state and its copy of the registers
    fcpr_phase_t  rx_phase;
    logic [15:0]  rx_len;
    logic [15:0]  rx_count;
    fcpr_cfg_t    rx_cfg;

    framed_cipher_packet_receiver dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_section       (m_section),
        .m_payload_byte  (m_payload_byte),
        .m_payload_index (m_payload_index),
        .m_section_last  (m_section_last),
        .m_packet_ready  (m_packet_ready),
        .m_framing_error (m_framing_error),
        .m_cipher_length (m_cipher_length),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always #6 aclk = ~aclk;

    function automatic void clear_parser();
        rx_phase = PH_SYNC1;
        rx_len   = 16'h0000;
        rx_count = 16'h0000;
    endfunction

    // one parser step: updates the model state and returns the expected result
    function automatic fcpr_result_t parse_byte(input logic op, input logic [7:0] b);
        fcpr_result_t  r;
        logic          err;
        logic          last;
        fcpr_section_t sec;
        int unsigned   limit;
        r     = '0;
        err   = 1'b0;
        sec   = SEC_NONE;
        limit = 0;
        if (op == OP_RESTART) begin
            clear_parser();
            return r;
        end
        case (rx_phase)
            PH_SYNC1: begin
                if (b == rx_cfg.sync_first)
                    rx_phase = PH_SYNC2;
            end
            PH_SYNC2: begin
                rx_phase = (b == rx_cfg.sync_second) ? PH_ALGO : PH_SYNC1;
            end
            PH_ALGO: begin
                if (b == rx_cfg.algorithm_code) begin
                    rx_phase = PH_MODE;
                end else begin
                    rx_phase = PH_ERROR;
                    err = 1'b1;
                end
            end
            PH_MODE: begin
                if (b == rx_cfg.mode_code) begin
                    rx_phase = PH_LEN_HI;
                end else begin
                    rx_phase = PH_ERROR;
                    err = 1'b1;
                end
            end
            PH_LEN_HI: begin
                rx_len   = {b, 8'h00};
                rx_phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                rx_len = rx_len | {8'h00, b};
                if (rx_len == 16'h0000 || rx_len > rx_cfg.max_cipher_length ||
                    (rx_len % BLOCK_LEN) != 0) begin
                    rx_phase = PH_ERROR;
                    err = 1'b1;
                end else begin
                    rx_phase = PH_IV;
                    rx_count = 16'h0000;
                end
            end
            PH_IV: begin
                sec   = SEC_IV;
                limit = IV_LEN;
            end
            PH_CIPHER: begin
                sec   = SEC_CIPHER;
                limit = 32'(rx_len);
            end
            PH_HASH: begin
                sec   = SEC_HASH;
                limit = HASH_LEN;
            end
            PH_READY: begin
            end
            // error state and unused codes: byte is dropped, parser cleared
            default: begin
                clear_parser();
            end
        endcase
        // payload byte tagged with its section and position
        if (sec != SEC_NONE) begin
            last            = (32'(rx_count) + 32'd1) >= limit;
            r.section       = sec;
            r.payload_byte  = b;
            r.payload_index = rx_count;
            r.section_last  = last;
            rx_count        = last ? 16'h0000 : rx_count + 16'd1;
            if (last)
                rx_phase = (sec == SEC_IV) ? PH_CIPHER :
                           (sec == SEC_CIPHER) ? PH_HASH : PH_READY;
        end
        r.packet_ready  = (rx_phase == PH_READY);
        r.framing_error = err;
        r.cipher_length = rx_len;
        return r;
    endfunction

    task automatic note_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
        // only the first PRINT_LIMIT are printed to keep the log short
        if (mismatch_count < PRINT_LIMIT)
            $display("%0t mismatch %s: got %0h, expected %0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // byte stream driver
    always @(posedge aclk) begin : drive_rx
        fcpr_item_t nxt;
        logic       offer;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                predicted.push_back(parse_byte(s_opcode, s_rx_byte));
            if (!s_valid || s_ready) begin
                offer = (rx_stream.size() > 0) && ($urandom_range(99) >= send_idle_pct);
                if (offer) begin
                    nxt = rx_stream.pop_front();
                    s_opcode  <= nxt.opcode;
                    s_rx_byte <= nxt.rx_byte;
                end
                s_valid <= offer;
            end
        end
    end

    // result back-pressure, with long hold-offs on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // result checker
    always @(posedge aclk) begin : check_results
        fcpr_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (predicted.size() == 0) begin
                note_mismatch("result with nothing predicted", m_payload_index, 16'h0000);
            end else begin
                want = predicted.pop_front();
                if (m_section !== want.section)
                    note_mismatch("section", 16'(m_section), 16'(want.section));
                if (m_payload_byte !== want.payload_byte)
                    note_mismatch("payload_byte", 16'(m_payload_byte),
                                  16'(want.payload_byte));
                if (m_payload_index !== want.payload_index)
                    note_mismatch("payload_index", m_payload_index, want.payload_index);
                if (m_section_last !== want.section_last)
                    note_mismatch("section_last", 16'(m_section_last),
                                  16'(want.section_last));
                if (m_packet_ready !== want.packet_ready)
                    note_mismatch("packet_ready", 16'(m_packet_ready),
                                  16'(want.packet_ready));
                if (m_framing_error !== want.framing_error)
                    note_mismatch("framing_error", 16'(m_framing_error),
                                  16'(want.framing_error));
                if (m_cipher_length !== want.cipher_length)
                    note_mismatch("cipher_length", m_cipher_length, want.cipher_length);
            end
        end
    end

    // register write transfer, mirrored into the model once accepted
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_SYNC_FIRST:  rx_cfg.sync_first        = val[7:0];
            CFG_SYNC_SECOND: rx_cfg.sync_second       = val[7:0];
            CFG_ALGORITHM:   rx_cfg.algorithm_code    = val[7:0];
            CFG_MODE:        rx_cfg.mode_code         = val[7:0];
            CFG_MAX_LENGTH:  rx_cfg.max_cipher_length = val;
            default: ;
        endcase
    endtask

    // new register set and traffic shape, only while the block is idle
    task automatic enter_phase(input int unsigned send_pct, input int unsigned recv_pct,
                               input logic [7:0] s1, input logic [7:0] s2,
                               input logic [7:0] algo, input logic [7:0] mode,
                               input logic [15:0] max_len);
        // upper data bits of the byte registers are random and must be dropped
        write_reg(CFG_SYNC_FIRST,  {8'($urandom), s1});
        write_reg(CFG_SYNC_SECOND, {8'($urandom), s2});
        write_reg(CFG_ALGORITHM,   {8'($urandom), algo});
        write_reg(CFG_MODE,        {8'($urandom), mode});
        write_reg(CFG_MAX_LENGTH,  max_len);
        @(negedge aclk);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (rx_stream.size() != 0 || s_valid || predicted.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    function automatic void push_item(input logic op, input logic [7:0] b);
        fcpr_item_t it;
        it.opcode  = op;
        it.rx_byte = b;
        rx_stream.push_back(it);
        stream_count++;
    endfunction

    function automatic void push_header(input logic [15:0] len);
        push_item(OP_DATA, rx_cfg.sync_first);
        push_item(OP_DATA, rx_cfg.sync_second);
        push_item(OP_DATA, rx_cfg.algorithm_code);
        push_item(OP_DATA, rx_cfg.mode_code);
        push_item(OP_DATA, len[15:8]);
        push_item(OP_DATA, len[7:0]);
    endfunction

    // full frame, or cut short after a number of payload bytes, then restart
    function automatic void queue_frame(input logic [15:0] len, input int cut);
        int total;
        total = IV_LEN + int'(len) + HASH_LEN;
        push_header(len);
        for (int i = 0; i < total && i != cut; i++)
            push_item(OP_DATA, 8'($urandom));
        // bytes after a complete packet are ignored
        if (cut < 0)
            repeat ($urandom_range(3)) push_item(OP_DATA, 8'($urandom));
        push_item(OP_RESTART, 8'($urandom));
    endfunction

    // mostly well-formed frames with random content, the rest broken or noise
    task automatic queue_traffic(input int unsigned n);
        int unsigned stop_at;
        int unsigned pick;
        int unsigned blocks;
        logic [15:0] len;
        stop_at = stream_count + n;
        while (stream_count < stop_at) begin
            pick   = $urandom_range(99);
            blocks = rx_cfg.max_cipher_length / BLOCK_LEN;
            if (blocks > 4)
                blocks = 4;
            if (pick < 65 && blocks > 0) begin
                len = 16'(BLOCK_LEN * $urandom_range(1, blocks));
                queue_frame(len, (pick < 55) ? -1 :
                            int'($urandom_range(IV_LEN + int'(len) + HASH_LEN - 1)));
            end else if (pick < 73) begin
                // bad algorithm byte, then the clearing byte
                push_item(OP_DATA, rx_cfg.sync_first);
                push_item(OP_DATA, rx_cfg.sync_second);
                push_item(OP_DATA, rx_cfg.algorithm_code ^ 8'($urandom_range(1, 255)));
                push_item(OP_DATA, 8'($urandom));
            end else if (pick < 80) begin
                // bad mode byte, then the clearing byte
                push_item(OP_DATA, rx_cfg.sync_first);
                push_item(OP_DATA, rx_cfg.sync_second);
                push_item(OP_DATA, rx_cfg.algorithm_code);
                push_item(OP_DATA, rx_cfg.mode_code ^ 8'($urandom_range(1, 255)));
                push_item(OP_DATA, 8'($urandom));
            end else if (pick < 90) begin
                // zero, oversized or misaligned length
                case ($urandom_range(2))
                    0: len = 16'h0000;
                    1: len = (rx_cfg.max_cipher_length == 16'hFFFF) ? 16'hFFFF :
                             16'($urandom_range(32'(rx_cfg.max_cipher_length) + 1, 65535));
                    default: len = 16'($urandom) | 16'($urandom_range(1, BLOCK_LEN - 1));
                endcase
                push_header(len);
                push_item(OP_DATA, 8'($urandom));
            end else if (pick < 95) begin
                // second sync byte wrong
                push_item(OP_DATA, rx_cfg.sync_first);
                push_item(OP_DATA, rx_cfg.sync_second ^ 8'($urandom_range(1, 255)));
            end else begin
                repeat ($urandom_range(1, 4))
                    push_item(($urandom_range(9) == 0) ? OP_RESTART : OP_DATA, 8'($urandom));
            end
        end
    endtask

    // sequencer
    initial begin
        clear_parser();
        rx_cfg = '{sync_first: 8'h00, sync_second: 8'h00, algorithm_code: 8'h00,
                   mode_code: 8'h00, max_cipher_length: MAX_LEN_RESET};
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // directed cases with the register reset values
        @(negedge aclk);
        push_item(OP_RESTART, 8'hFF);
        push_item(OP_DATA, 8'hFF);                     // first sync mismatch
        push_item(OP_DATA, 8'h00);
        push_item(OP_DATA, 8'hFF);                     // second sync mismatch
        push_item(OP_DATA, 8'h00);
        push_item(OP_DATA, 8'h00);
        push_item(OP_DATA, 8'hFF);                     // bad algorithm
        push_item(OP_DATA, 8'h00);                     // clearing byte looks like a sync
        push_item(OP_DATA, 8'h00);
        push_item(OP_DATA, 8'h00);
        push_item(OP_DATA, 8'h00);
        push_item(OP_DATA, 8'h80);                     // bad mode
        push_item(OP_DATA, 8'hFF);
        push_header(16'h0000);                         // zero length
        push_item(OP_DATA, 8'h5A);
        push_header(16'hFFFF);                         // oversized and misaligned
        push_item(OP_DATA, 8'hA5);
        push_header(16'h0010);
        push_item(OP_RESTART, 8'h00);                  // restart before the payload
        wait_drained();

        // no idling; long receiver hold-off, then a long frame
        enter_phase(0, 0, 8'hFF, 8'h00, 8'($urandom), 8'($urandom), 16'hFFFF);
        write_reg(3'(CFG_MAX_LENGTH) + 3'd1 + 3'($urandom_range(2)), 16'($urandom));
        queue_traffic(30);
        hold_request = 150;
        wait_drained();
        queue_frame(16'h0080, -1);
        queue_traffic(30);
        wait_drained();

        // sender idling, extreme codes, tightest length limit
        enter_phase(53, 0, 8'h00, 8'hFF, 8'h00, 8'hFF, 16'h0010);
        queue_traffic(40);
        wait_drained();

        // receiver stalling, reset length limit
        enter_phase(0, 53, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                    MAX_LEN_RESET);
        queue_traffic(40);
        wait_drained();

        // both idling, random length limit
        enter_phase(26, 26, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                    16'(BLOCK_LEN * $urandom_range(2, 64)));
        queue_traffic(40);
        wait_drained();

        // both idling, equal sync bytes, every length rejected
        begin : equal_sync
            logic [7:0] s;
            s = 8'($urandom);
            enter_phase(26, 26, s, s, 8'($urandom), 8'($urandom), 16'h0000);
        end
        queue_traffic(20);
        wait_drained();

        if (mismatch_count == 0 && predicted.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // run limit
    initial begin
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
